// ----- rtl/btmx_pkg.sv -----
// Shared constants, types and helpers for the binary trie max-xor block.
// Used by the top level, the node memory and the port checker.
package btmx_pkg;

    localparam int KEY_BITS  = 32;
    localparam int MAX_NODES = 4096;
    localparam int WORD_W    = 32;

    localparam int NODE_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W  = $clog2(MAX_NODES + 1);
    localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;

    localparam int FULL_LIMIT = MAX_NODES - KEY_BITS;

    typedef logic [NODE_W-1:0] node_idx_t;

    typedef struct packed {
        node_idx_t one;
        node_idx_t zero;
    } link_pair_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    function automatic logic [KEY_BITS-1:0] fit_key(input logic [WORD_W-1:0] k);
        logic [63:0] e;
        e = {32'b0, k};
        return e[KEY_BITS-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] to_word(input logic [KEY_BITS-1:0] b);
        logic [63:0] e;
        e = 64'(b);
        return e[WORD_W-1:0];
    endfunction

endpackage

// ----- rtl/btmx_node_ram.sv -----
// Trie node memory: one write port, one read port with registered read data.
// Depends on btmx_pkg for the node index and link pair types.
module btmx_node_ram
(
    input  logic                  clk,
    input  logic                  wr_en,
    input  btmx_pkg::node_idx_t   wr_addr,
    input  btmx_pkg::link_pair_t  wr_data,
    input  logic                  rd_en,
    input  btmx_pkg::node_idx_t   rd_addr,
    output btmx_pkg::link_pair_t  rd_data
);

    btmx_pkg::link_pair_t mem [btmx_pkg::MAX_NODES];
    btmx_pkg::link_pair_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/binary_trie_max_xor.sv -----
// Binary trie max-xor engine: top level with walk sequencer and result register.
// Depends on btmx_pkg and btmx_node_ram.
//
// Each item either inserts a key into the trie or asks for the largest xor of
// the key with any stored key. Inserts and queries walk one trie level per
// cycle, reading one node from the node memory per cycle; a refused insert or a
// query on an empty trie skips the walk and goes straight to the finish state;
// in_stall is high while an item is in work. The
// result sits in an output register, so the next item is taken while it waits.
// Nodes are allocated in order and never freed; an insert is refused with
// status full when fewer than KEY_BITS nodes are left. The root lives in
// flip-flops, so no memory clearing is needed after reset.
module binary_trie_max_xor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        mode,
    input  logic [31:0] key,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] best_xor,
    output logic [1:0]  status
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } state_t;

    state_t                            state_reg, state_next;
    logic                              mode_reg, mode_next;
    logic [btmx_pkg::KEY_BITS-1:0]     key_reg, key_next;
    logic [btmx_pkg::KEY_BITS-1:0]     best_reg, best_next;
    logic [btmx_pkg::LVL_W-1:0]        lvl_reg, lvl_next;
    btmx_pkg::node_idx_t               cur_reg, cur_next;
    logic                              fresh_reg, fresh_next;
    logic [btmx_pkg::CNT_W-1:0]        free_reg, free_next;
    logic                              has_entries_reg, has_entries_next;
    btmx_pkg::link_pair_t              root_reg, root_next;
    btmx_pkg::status_t                 res_status_reg, res_status_next;
    logic                              out_valid_reg, out_valid_next;
    logic [31:0]                       out_best_reg, out_best_next;
    btmx_pkg::status_t                 out_status_reg, out_status_next;

    btmx_pkg::link_pair_t              links;
    btmx_pkg::link_pair_t              ram_rd_data;
    btmx_pkg::link_pair_t              wr_data;
    logic                              wr_en;
    logic                              rd_en;
    btmx_pkg::node_idx_t               nxt;
    btmx_pkg::node_idx_t               child_same;
    btmx_pkg::node_idx_t               child_opp;
    logic                              key_bit;
    logic                              pool_full;

    btmx_node_ram u_node_ram
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cur_reg),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (nxt),
        .rd_data (ram_rd_data)
    );

    assign links      = fresh_reg ? '0 : ((cur_reg == '0) ? root_reg : ram_rd_data);
    assign key_bit    = key_reg[lvl_reg];
    assign child_same = key_bit ? links.one : links.zero;
    assign child_opp  = key_bit ? links.zero : links.one;
    assign pool_full  = free_reg > btmx_pkg::CNT_W'(btmx_pkg::FULL_LIMIT);

    always_comb
    begin
        state_next       = state_reg;
        mode_next        = mode_reg;
        key_next         = key_reg;
        best_next        = best_reg;
        lvl_next         = lvl_reg;
        cur_next         = cur_reg;
        fresh_next       = fresh_reg;
        free_next        = free_reg;
        has_entries_next = has_entries_reg;
        root_next        = root_reg;
        res_status_next  = res_status_reg;
        out_valid_next   = out_valid_reg && out_stall;
        out_best_next    = out_best_reg;
        out_status_next  = out_status_reg;
        wr_en            = 1'b0;
        rd_en            = 1'b0;
        wr_data          = links;
        nxt              = child_same;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next       = mode;
                    key_next        = btmx_pkg::fit_key(key);
                    best_next       = '0;
                    lvl_next        = btmx_pkg::LVL_W'(btmx_pkg::KEY_BITS - 1);
                    cur_next        = '0;
                    fresh_next      = 1'b0;
                    res_status_next = btmx_pkg::ST_OK;
                    state_next      = S_WALK;
                    if (mode == btmx_pkg::MODE_INSERT)
                    begin
                        if (pool_full)
                        begin
                            res_status_next = btmx_pkg::ST_FULL;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            has_entries_next = 1'b1;
                        end
                    end
                    else if (!has_entries_reg)
                    begin
                        res_status_next = btmx_pkg::ST_EMPTY;
                        state_next      = S_FINISH;
                    end
                end
            end

            S_WALK:
            begin
                if (mode_reg == btmx_pkg::MODE_INSERT)
                begin
                    fresh_next = 1'b0;
                    if (child_same == '0)
                    begin
                        nxt        = free_reg[btmx_pkg::NODE_W-1:0];
                        free_next  = free_reg + 1'b1;
                        fresh_next = 1'b1;
                        if (key_bit)
                        begin
                            wr_data.one = nxt;
                        end
                        else
                        begin
                            wr_data.zero = nxt;
                        end
                        if (cur_reg == '0)
                        begin
                            root_next = wr_data;
                        end
                        else
                        begin
                            wr_en = 1'b1;
                        end
                    end
                    else
                    begin
                        rd_en = 1'b1;
                    end
                    cur_next = nxt;
                    if (lvl_reg == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
                else
                begin
                    fresh_next = 1'b0;
                    if (child_opp != '0)
                    begin
                        nxt                = child_opp;
                        best_next[lvl_reg] = 1'b1;
                    end
                    cur_next = nxt;
                    if (lvl_reg == '0 || nxt == '0)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        rd_en    = 1'b1;
                        lvl_next = lvl_reg - 1'b1;
                    end
                end
            end

            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_best_next   = (mode_reg == btmx_pkg::MODE_QUERY)
                                      ? btmx_pkg::to_word(best_reg) : '0;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            mode_reg        <= btmx_pkg::MODE_INSERT;
            key_reg         <= '0;
            best_reg        <= '0;
            lvl_reg         <= '0;
            cur_reg         <= '0;
            fresh_reg       <= 1'b0;
            free_reg        <= btmx_pkg::CNT_W'(1);
            has_entries_reg <= 1'b0;
            root_reg        <= '0;
            res_status_reg  <= btmx_pkg::ST_OK;
            out_valid_reg   <= 1'b0;
            out_best_reg    <= '0;
            out_status_reg  <= btmx_pkg::ST_OK;
        end
        else
        begin
            state_reg       <= state_next;
            mode_reg        <= mode_next;
            key_reg         <= key_next;
            best_reg        <= best_next;
            lvl_reg         <= lvl_next;
            cur_reg         <= cur_next;
            fresh_reg       <= fresh_next;
            free_reg        <= free_next;
            has_entries_reg <= has_entries_next;
            root_reg        <= root_next;
            res_status_reg  <= res_status_next;
            out_valid_reg   <= out_valid_next;
            out_best_reg    <= out_best_next;
            out_status_reg  <= out_status_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign best_xor  = out_best_reg;
    assign status    = out_status_reg;

endmodule

// ----- rtl/btmx_checker.sv -----
// Port-level assertions for binary_trie_max_xor, attached by bind.
// Depends on btmx_pkg for the status codes.
module btmx_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] best_xor,
    input logic [1:0]  status
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(best_xor) && $stable(status))
        else $error("stalled result changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted back to back");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == btmx_pkg::ST_OK || status == btmx_pkg::ST_EMPTY ||
                       status == btmx_pkg::ST_FULL))
        else $error("bad status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != btmx_pkg::ST_OK |-> best_xor == '0)
        else $error("nonzero xor with error status");

endmodule

bind binary_trie_max_xor btmx_checker u_btmx_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .best_xor  (best_xor),
    .status    (status)
);
